FILE: rtl/lwac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lwac_pkg - shared types and constants for the long wake-up alarm chainer
// holds the item and result structs, the item kind codes and the chunk alarm
// ---------------------------------------------------------------------------
package lwac_pkg;

    // item kind codes
    typedef enum logic {
        KIND_ARM   = 1'b0,
        KIND_EVENT = 1'b1
    } t_kind;

    // one chunk is 65536 s, armed as 18:12:16
    localparam logic [31:0] DATE_MASK_BIT = 32'h8000_0000;
    localparam logic [31:0] CHUNK_HMS     = 32'h0018_1216;
    localparam logic [31:0] CHUNK_WORD    = DATE_MASK_BIT | CHUNK_HMS;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] timeout_seconds;
        logic        alarm_pending;
    } t_item;

    typedef struct packed {
        logic        program_alarm;
        logic [31:0] alarm_word;
        logic        restart_clock;
        logic        request_reset;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/lwac_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lwac_ifs - valid/ready channels of the long wake-up alarm chainer
// item channel in, result channel out
// ---------------------------------------------------------------------------
interface lwac_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] timeout_seconds;
    logic        alarm_pending;

    modport source (output valid, output kind, output timeout_seconds,
                    output alarm_pending, input ready);
    modport sink   (input valid, input kind, input timeout_seconds,
                    input alarm_pending, output ready);
endinterface

interface lwac_out_if;
    logic        valid;
    logic        ready;
    logic        program_alarm;
    logic [31:0] alarm_word;
    logic        restart_clock;
    logic        request_reset;

    modport source (output valid, output program_alarm, output alarm_word,
                    output restart_clock, output request_reset, input ready);
    modport sink   (input valid, input program_alarm, input alarm_word,
                    input restart_clock, input request_reset, output ready);
endinterface
`default_nettype wire

FILE: rtl/lwac_bcd.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lwac_bcd - seconds to bcd hh:mm:ss alarm word
// splits a value under 65536 s into hours, minutes and seconds by reciprocal
// multiplication and packs them with the date mask bit
// ---------------------------------------------------------------------------
module lwac_bcd (
    input  wire logic [15:0] i_secs,
    output logic      [31:0] o_word
);
    import lwac_pkg::*;

    // x < 64: tens by (x * 13) >> 7, ones by subtraction
    function automatic logic [6:0] to_bcd(input logic [5:0] x);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [3:0] ones;
        prod = 10'(x) * 10'd13;
        tens = prod[9:7];
        ones = 4'(x - 6'(tens) * 6'd10);
        return {tens, ones};
    endfunction

    logic [31:0] w_hprod;
    logic [4:0]  w_hours;
    logic [15:0] w_hsecs;
    logic [11:0] w_rem;
    logic [23:0] w_mprod;
    logic [5:0]  w_mins;
    logic [5:0]  w_secs;
    logic [6:0]  w_h_bcd;
    logic [6:0]  w_m_bcd;
    logic [6:0]  w_s_bcd;

    always_comb begin
        // /3600 as * 37283 >> 27, exact below 125203
        w_hprod = 32'(i_secs) * 32'd37283;
        w_hours = w_hprod[31:27];
        w_hsecs = 16'(w_hours) * 16'd3600;
        w_rem   = 12'(i_secs - w_hsecs);
        // /60 as * 2185 >> 17, exact below 4681
        w_mprod = 24'(w_rem) * 24'd2185;
        w_mins  = w_mprod[22:17];
        w_secs  = 6'(w_rem - 12'(w_mins) * 12'd60);
        w_h_bcd = to_bcd(6'(w_hours));
        w_m_bcd = to_bcd(w_mins);
        w_s_bcd = to_bcd(w_secs);
        o_word  = DATE_MASK_BIT
                | {10'd0, w_h_bcd[5:0], 1'b0, w_m_bcd, 1'b0, w_s_bcd};
    end

endmodule
`default_nettype wire

FILE: rtl/lwac_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lwac_seq - chaining state and per-item decision
// keeps the remaining count, the final alarm word and the armed flag, and
// forms the result of the item held in the input register
// ---------------------------------------------------------------------------
module lwac_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire lwac_pkg::t_item   i_item,
    output lwac_pkg::t_result      o_result
);
    import lwac_pkg::*;

    logic [31:0] r_secs_rem;
    logic [31:0] r_final_alarm;
    logic        r_armed;
    logic [31:0] n_secs_rem;
    logic [31:0] n_final_alarm;
    logic        n_armed;

    logic [31:0] w_bcd_word;
    logic        w_new_big;
    logic        w_rem_big;

    lwac_bcd u_bcd (
        .i_secs (i_item.timeout_seconds[15:0]),
        .o_word (w_bcd_word)
    );

    // a full chunk or more left
    assign w_new_big = |i_item.timeout_seconds[31:16];
    assign w_rem_big = |r_secs_rem[31:16];

    always_comb begin
        n_secs_rem    = r_secs_rem;
        n_final_alarm = r_final_alarm;
        n_armed       = r_armed;
        o_result      = '0;
        if (i_item.kind == KIND_ARM) begin
            if (i_item.timeout_seconds == 32'd0) begin
                n_armed    = 1'b0;
                n_secs_rem = 32'd0;
            end else begin
                n_final_alarm          = w_bcd_word;
                n_armed                = 1'b1;
                o_result.restart_clock = 1'b1;
                o_result.program_alarm = 1'b1;
                if (w_new_big) begin
                    o_result.alarm_word = CHUNK_WORD;
                    n_secs_rem = {i_item.timeout_seconds[31:16] - 16'd1,
                                  i_item.timeout_seconds[15:0]};
                end else begin
                    o_result.alarm_word = w_bcd_word;
                    n_secs_rem = 32'd0;
                end
            end
        end else if (r_armed && i_item.alarm_pending) begin
            if (r_secs_rem == 32'd0) begin
                o_result.request_reset = 1'b1;
                n_armed = 1'b0;
            end else begin
                o_result.restart_clock = 1'b1;
                if (w_rem_big) begin
                    // same chunk length, alarm word stays
                    n_secs_rem = {r_secs_rem[31:16] - 16'd1, r_secs_rem[15:0]};
                end else begin
                    o_result.program_alarm = 1'b1;
                    o_result.alarm_word    = r_final_alarm;
                    n_secs_rem = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secs_rem    <= '0;
            r_final_alarm <= '0;
            r_armed       <= 1'b0;
        end else if (i_fire) begin
            r_secs_rem    <= n_secs_rem;
            r_final_alarm <= n_final_alarm;
            r_armed       <= n_armed;
        end
    end

    // nothing may be left to chain once disarmed
    a_disarmed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> r_secs_rem == 32'd0)
        else $error("remaining count nonzero while disarmed");

    // an expiry disarms the block
    a_reset_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.request_reset |=> !r_armed)
        else $error("still armed after reset request");

    // an expiry programs nothing and restarts nothing
    a_reset_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.request_reset |-> !o_result.program_alarm && !o_result.restart_clock)
        else $error("reset request mixed with alarm actions");

    // a programmed word always masks the date
    a_word_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.program_alarm && (r_armed || i_item.kind == KIND_ARM)
        |-> o_result.alarm_word[31])
        else $error("alarm word without date mask");

endmodule
`default_nettype wire

FILE: rtl/long_wakeup_alarm_chainer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// long_wakeup_alarm_chainer_top - long wake-up alarm chainer
// chains 65536 s alarms of 18:12:16 and one final bcd alarm to reach
// timeouts of up to 2^32 - 1 s, then asks for a system reset
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  i_in    | in  | kind, timeout_seconds, alarm_pending             | valid/ready
//  o_out   | out | program_alarm, alarm_word, restart_clock,        | valid/ready
//          |     | request_reset                                    |
//
//  one result per item, held first in the input register, then in the result register
//  a new item can be taken every cycle while results are taken; the bcd split
//  of the final remainder (two reciprocal multiplies) sets the cycle time
//  reset: synchronous, active low; clears both stage valids and the state
//  a stalled result holds while the input register still takes one item
//
module long_wakeup_alarm_chainer_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lwac_in_if.sink    i_in,
    lwac_out_if.source o_out
);
    import lwac_pkg::*;

    // input register
    logic    r_in_vld;
    t_item   r_item;
    // result register
    logic    r_out_vld;
    t_result r_result;

    logic    w_in_xfer;
    logic    w_adv;
    t_result w_result;

    // the held item moves on when the result register is free or drains now
    assign w_adv     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_in_xfer = i_in.valid && i_in.ready;

    // state update and result of the held item
    lwac_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_item   (r_item),
        .o_result (w_result)
    );

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= w_in_xfer || (r_in_vld && !w_adv);
            r_out_vld <= w_adv || (r_out_vld && !o_out.ready);
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item.kind            <= t_kind'(i_in.kind);
            r_item.timeout_seconds <= i_in.timeout_seconds;
            r_item.alarm_pending   <= i_in.alarm_pending;
        end
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.program_alarm = r_result.program_alarm;
    assign o_out.alarm_word    = r_result.alarm_word;
    assign o_out.restart_clock = r_result.restart_clock;
    assign o_out.request_reset = r_result.request_reset;

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> !r_out_vld || o_out.ready)
        else $error("result register overwritten while stalled");

    // every moved item lands as a result
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("advanced item lost");

    // the input register is never refilled while its item is still held
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> !r_in_vld || w_adv)
        else $error("held item dropped");

endmodule
`default_nettype wire

FILE: verif/alarm_chain_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alarm_chain_checker - result checker for the long wake-up alarm chainer
// watches both channels, runs its own copy of the chaining rules on every
// item transfer and compares every result transfer, field by field, with the
// oldest outstanding prediction
// ---------------------------------------------------------------------------
module alarm_chain_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lwac_in_if          i_item_ch,
    lwac_out_if         i_result_ch,
    output int unsigned o_mismatches,
    output int unsigned o_awaited
);
    import lwac_pkg::*;

    localparam logic [31:0] CHUNK_SECONDS = 32'h0001_0000;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    // predictor state
    logic [31:0] secs_left = '0;
    logic [31:0] last_word = '0;
    logic        is_armed  = 1'b0;

    t_result     due_results[$];
    int unsigned mismatches = 0;

    assign o_mismatches = mismatches;

    // bcd hh:mm:ss with the date masked
    function automatic logic [31:0] hms_alarm_word(logic [15:0] secs);
        int unsigned hrs;
        int unsigned mins;
        int unsigned sc;
        hrs  = secs / SECS_PER_HOUR;
        mins = (secs % SECS_PER_HOUR) / SECS_PER_MIN;
        sc   = secs % SECS_PER_MIN;
        return DATE_MASK_BIT
             | (32'(hrs / 10) << 20)  | (32'(hrs % 10) << 16)
             | (32'(mins / 10) << 12) | (32'(mins % 10) << 8)
             | (32'(sc / 10) << 4)    | 32'(sc % 10);
    endfunction

    function automatic t_result chain_step(t_item it);
        t_result r;
        r = '0;
        if (it.kind == KIND_ARM) begin
            if (it.timeout_seconds == '0) begin
                is_armed  = 1'b0;
                secs_left = '0;
            end else begin
                last_word       = hms_alarm_word(it.timeout_seconds[15:0]);
                r.restart_clock = 1'b1;
                r.program_alarm = 1'b1;
                is_armed        = 1'b1;
                if (it.timeout_seconds >= CHUNK_SECONDS) begin
                    r.alarm_word = CHUNK_WORD;
                    secs_left    = it.timeout_seconds - CHUNK_SECONDS;
                end else begin
                    r.alarm_word = last_word;
                    secs_left    = '0;
                end
            end
        end else if (is_armed && it.alarm_pending) begin
            if (secs_left == '0) begin
                // timeout fully expired, system reset disarms
                r.request_reset = 1'b1;
                is_armed        = 1'b0;
            end else begin
                r.restart_clock = 1'b1;
                if (secs_left >= CHUNK_SECONDS) begin
                    // same chunk again, alarm word kept
                    secs_left = secs_left - CHUNK_SECONDS;
                end else begin
                    r.program_alarm = 1'b1;
                    r.alarm_word    = last_word;
                    secs_left       = '0;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_item   seen;
        if (!i_rst_n) begin
            secs_left = '0;
            last_word = '0;
            is_armed  = 1'b0;
            due_results.delete();
        end else begin
            if (i_result_ch.valid && i_result_ch.ready) begin
                got.program_alarm = i_result_ch.program_alarm;
                got.alarm_word    = i_result_ch.alarm_word;
                got.restart_clock = i_result_ch.restart_clock;
                got.request_reset = i_result_ch.request_reset;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("program_alarm", 32'(want.program_alarm),
                                32'(got.program_alarm));
                    check_field("alarm_word", want.alarm_word, got.alarm_word);
                    check_field("restart_clock", 32'(want.restart_clock),
                                32'(got.restart_clock));
                    check_field("request_reset", 32'(want.request_reset),
                                32'(got.request_reset));
                end
            end
            if (i_item_ch.valid && i_item_ch.ready) begin
                seen.kind            = t_kind'(i_item_ch.kind);
                seen.timeout_seconds = i_item_ch.timeout_seconds;
                seen.alarm_pending   = i_item_ch.alarm_pending;
                due_results.push_back(chain_step(seen));
            end
        end
        o_awaited <= due_results.size();
    end

endmodule

FILE: verif/long_wakeup_alarm_chainer_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// long_wakeup_alarm_chainer_top_test - testbench of the alarm chainer
// drives arm items and alarm events, directed corner cases first and then
// random chains, most of which run to the final alarm and the reset request, with
// random idling on both sides; a checker beside the block predicts and
// compares every result
// ---------------------------------------------------------------------------
module long_wakeup_alarm_chainer_top_test;
    import lwac_pkg::*;

    localparam int unsigned ITEM_TARGET = 1600;
    // longest correct quiet spell is the receiver hold-off below
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    // time through the input and result registers of the block, plus margin
    localparam int unsigned TAIL_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned awaited;
    int unsigned items_done = 0;
    int unsigned stall_cycles = 0;

    // random idling on both sides, switched off for one long stretch
    bit          idle_on = 1'b1;
    // set once by the stimulus; the receiver holds off a single time
    bit          hold_request = 1'b0;

    lwac_in_if  in_ch ();
    lwac_out_if out_ch ();

    long_wakeup_alarm_chainer_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    alarm_chain_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item_ch    (in_ch),
        .i_result_ch  (out_ch),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: ends the run when neither channel has moved for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random back-pressure, and one long hold-off on request
    initial begin
        bit hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 8);
            end
        end
    end

    // one transfer on the item channel; valid stays high afterwards so that
    // back-to-back items need no second assignment in the same step
    task automatic offer_item(t_kind k, logic [31:0] tmo, logic pend);
        if (idle_on && $urandom_range(0, 99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= k;
        in_ch.timeout_seconds <= tmo;
        in_ch.alarm_pending   <= pend;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // sender pauses until every outstanding result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
    endtask

    // one arm item followed by the events that walk its chunks down to the
    // reset request; some chains are cut short, some get spurious events
    task automatic random_chain();
        logic [31:0] tmo;
        int unsigned roll;
        int unsigned n_events;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            tmo = '0;
        end else if (roll < 15) begin
            tmo = $urandom();
        end else begin
            tmo = {16'($urandom_range(0, 5)), 16'($urandom())};
            if (tmo == '0) tmo = 32'd1;
        end
        offer_item(KIND_ARM, tmo, 1'($urandom()));
        items_done++;
        if (tmo == '0) return;
        // full-range timeouts would need thousands of events: cut them short
        if (tmo[31:16] > 6) n_events = $urandom_range(1, 6);
        else n_events = tmo[31:16] + 1;
        if ($urandom_range(0, 9) == 0) n_events = $urandom_range(0, n_events);
        for (int i = 0; i < n_events; i++) begin
            if ($urandom_range(0, 99) < 8) offer_item(KIND_EVENT, $urandom(), 1'b0);
            offer_item(KIND_EVENT, $urandom(), 1'b1);
            items_done++;
        end
        // stray event after the chain has finished, normally ignored
        if ($urandom_range(0, 9) == 0) offer_item(KIND_EVENT, $urandom(), 1'($urandom()));
    endtask

    initial begin
        bit held = 1'b0;
        bit paused_a = 1'b0;
        bit paused_b = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.kind            = KIND_ARM;
        in_ch.timeout_seconds = '0;
        in_ch.alarm_pending   = 1'b0;
        rst_n                 = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // events and disarm before anything is armed
        offer_item(KIND_EVENT, 32'hffff_ffff, 1'b1);
        offer_item(KIND_EVENT, 32'h0000_0000, 1'b0);
        offer_item(KIND_ARM,   32'd0,         1'b1);
        // shortest timeout, spurious event, then the reset request
        offer_item(KIND_ARM,   32'd1,         1'b0);
        offer_item(KIND_EVENT, 32'd0,         1'b0);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        // longest single alarm, 18:12:15
        offer_item(KIND_ARM,   32'd65535,     1'b1);
        offer_item(KIND_EVENT, 32'hffff_ffff, 1'b1);
        // exactly one chunk, nothing left after it
        offer_item(KIND_ARM,   32'd65536,     1'b0);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        // one chunk plus one second
        offer_item(KIND_ARM,   32'd65537,     1'b0);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        // three chunks and a remainder of 12:34:56
        offer_item(KIND_ARM,   32'(3 * 65536 + 45296), 1'b0);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        // largest timeout, then re-arm twice while armed, then disarm
        offer_item(KIND_ARM,   32'hffff_ffff, 1'b1);
        offer_item(KIND_EVENT, 32'd0,         1'b0);
        offer_item(KIND_EVENT, 32'd0,         1'b1);
        offer_item(KIND_ARM,   32'd200000,    1'b0);
        offer_item(KIND_ARM,   32'd35999,     1'b0);
        offer_item(KIND_ARM,   32'd0,         1'b0);
        offer_item(KIND_EVENT, 32'hffff_ffff, 1'b1);

        while (items_done < ITEM_TARGET) begin
            // long receiver hold-off: the block fills and stalls its input
            if (!held && items_done >= 300) begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            // one long stretch with no idling on either side
            idle_on = !(items_done >= 600 && items_done < 900);
            if (!paused_a && items_done >= 1000) begin
                paused_a = 1'b1;
                drain_results();
            end
            if (!paused_b && items_done >= 1400) begin
                paused_b = 1'b1;
                drain_results();
            end
            random_chain();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
